// ===== rtl/dcp_pkg.sv =====
// Package for the dollar command parser: item and result types, character
// constants, keyword matcher states and the default capture window.
// Depends on nothing; the parser core and the top level import it.
package dcp_pkg;

	localparam int unsigned CAPTURE_WINDOW = 8;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned DUTY_W = 7;

	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

	localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

	typedef enum logic [3:0] {
		MS_IDLE,
		MS_DOL,
		MS_A,
		MS_AU,
		MS_AUT,
		MS_AUTO,
		MS_M,
		MS_MA,
		MS_MAN,
		MS_MANU,
		MS_MANUA,
		MS_MANUAL,
		MS_P,
		MS_PW,
		MS_NONE,
		MS_DIG
	} match_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic [DUTY_W-1:0] current_intensity;
		logic              last_in_chunk;
	} dcp_item_t;

	typedef struct packed {
		logic              manual_mode;
		logic [DUTY_W-1:0] duty_value;
		logic              duty_updated;
	} dcp_result_t;

endpackage

// ===== rtl/dcp_stream_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
// Used by the dollar command parser for its byte input and result output.
interface dcp_stream_if #(
	parameter type item_t = logic
) ();

	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ===== rtl/dcp_parse_core.sv =====
// Parser state and the per-byte next-state logic of the dollar command parser.
// Depends on dcp_pkg for item, result and matcher state types.
module dcp_parse_core #(
	parameter int unsigned CaptureWindow = dcp_pkg::CAPTURE_WINDOW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  dcp_pkg::dcp_item_t  item,
	output dcp_pkg::dcp_result_t result
);

	import dcp_pkg::*;

	localparam int unsigned CntW = $clog2(CaptureWindow + 1);

	logic               cap_q, cap_d;
	match_state_t       ms_q, ms_d;
	logic [CntW-1:0]    cnt_q, cnt_d;
	logic [1:0]         dc_q, dc_d;
	logic [DUTY_W-1:0]  acc_q, acc_d;
	logic               mode_q, mode_d;
	logic [DUTY_W-1:0]  duty_q, duty_d;

	logic               upd;
	logic               done;
	logic               dol_hit;
	logic               is_digit;
	logic [10:0]        acc_wide;
	logic [DUTY_W-1:0]  inten_sat;
	logic [BYTE_W-1:0]  b;

	assign b         = item.rx_byte;
	assign dol_hit   = (b == CH_DOLLAR);
	assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
	assign acc_wide  = 11'(acc_q) * 11'd10 + 11'(b[3:0]);
	assign inten_sat = (item.current_intensity > DUTY_MAX) ? DUTY_MAX : item.current_intensity;

	always_comb begin
		cap_d  = cap_q;
		ms_d   = ms_q;
		cnt_d  = cnt_q;
		dc_d   = dc_q;
		acc_d  = acc_q;
		mode_d = mode_q;
		duty_d = duty_q;
		upd    = 1'b0;
		done   = 1'b0;
		if (!cap_q) begin
			if (dol_hit) begin
				cap_d = 1'b1;
				cnt_d = CntW'(1);
				ms_d  = MS_DOL;
				dc_d  = 2'd0;
				acc_d = '0;
			end
		end else begin
			cnt_d = cnt_q + CntW'(1);
			if (ms_q == MS_DIG) begin
				if (dc_q[1]) begin
					if (dol_hit) begin
						duty_d = acc_q;
						upd    = 1'b1;
					end
					done = 1'b1;
				end else if (is_digit) begin
					acc_d = acc_wide[DUTY_W-1:0];
					dc_d  = dc_q + 2'd1;
				end
			end else if (dol_hit) begin
				if (ms_q == MS_AUTO) begin
					mode_d = 1'b0;
					done   = 1'b1;
				end else if (ms_q == MS_MANUAL) begin
					duty_d = inten_sat;
					mode_d = 1'b1;
					upd    = 1'b1;
					done   = 1'b1;
				end else begin
					ms_d = MS_DOL;
				end
			end else begin
				case (ms_q)
					MS_DOL: begin
						if (b == "a") ms_d = MS_A;
						else if (b == "m") ms_d = MS_M;
						else if (b == "P") ms_d = MS_P;
						else ms_d = MS_NONE;
					end
					MS_A:     ms_d = (b == "u") ? MS_AU : MS_NONE;
					MS_AU:    ms_d = (b == "t") ? MS_AUT : MS_NONE;
					MS_AUT:   ms_d = (b == "o") ? MS_AUTO : MS_NONE;
					MS_M:     ms_d = (b == "a") ? MS_MA : MS_NONE;
					MS_MA:    ms_d = (b == "n") ? MS_MAN : MS_NONE;
					MS_MAN:   ms_d = (b == "u") ? MS_MANU : MS_NONE;
					MS_MANU:  ms_d = (b == "a") ? MS_MANUA : MS_NONE;
					MS_MANUA: ms_d = (b == "l") ? MS_MANUAL : MS_NONE;
					MS_P:     ms_d = (b == "W") ? MS_PW : MS_NONE;
					MS_PW: begin
						if ((b == "M") && mode_q) begin
							ms_d  = MS_DIG;
							dc_d  = 2'd0;
							acc_d = '0;
						end else begin
							ms_d = MS_NONE;
						end
					end
					default: ms_d = MS_NONE;
				endcase
			end
			if (done || (cnt_d >= CntW'(CaptureWindow))) begin
				cap_d = 1'b0;
				ms_d  = MS_IDLE;
				cnt_d = '0;
				dc_d  = 2'd0;
				acc_d = '0;
			end
		end
		if (item.last_in_chunk) begin
			cap_d = 1'b0;
			ms_d  = MS_IDLE;
			cnt_d = '0;
			dc_d  = 2'd0;
			acc_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= 1'b0;
			ms_q   <= MS_IDLE;
			cnt_q  <= '0;
			dc_q   <= 2'd0;
			acc_q  <= '0;
			mode_q <= 1'b0;
			duty_q <= '0;
		end else if (advance) begin
			cap_q  <= cap_d;
			ms_q   <= ms_d;
			cnt_q  <= cnt_d;
			dc_q   <= dc_d;
			acc_q  <= acc_d;
			mode_q <= mode_d;
			duty_q <= duty_d;
		end
	end

	assign result.manual_mode  = mode_d;
	assign result.duty_value   = duty_d;
	assign result.duty_updated = upd;

endmodule

// ===== rtl/dollar_command_parser_unit.sv =====
// Top level of the dollar command parser: input register, parser core and
// result register. Depends on dcp_pkg, dcp_stream_if and dcp_parse_core.
//
// The block takes one received byte per item on cmd, together with the
// present intensity and an end-of-chunk mark, and returns one item per
// byte on status: mode, duty percent and a flag set when the byte finished
// $manual$ or a valid $PWMnn$ command.
// An accepted item is held in the input register and parsed there, and
// its result is written to the result register once that register is
// free or being taken; status valid and data come from that register.
// One item is accepted in every cycle while the result register is free
// or being taken; the parser next-state logic is combinational and
// closes on its own state registers.
// When the receiver holds status ready low, the result waits in place, the
// input register still fills once, and cmd ready then drops until status
// ready returns. Reset clears both valid flags, leaves no capture in
// progress, selects automatic mode and sets the duty value to zero.
module dollar_command_parser_unit #(
	parameter int unsigned CaptureWindow = dcp_pkg::CAPTURE_WINDOW
) (
	input  logic         clk,
	input  logic         arst_n,
	dcp_stream_if.sink   cmd,
	dcp_stream_if.source status
);

	import dcp_pkg::*;

	logic        valid_s1;
	dcp_item_t   item_s1;
	logic        res_valid_q;
	dcp_result_t res_q;
	dcp_result_t res_d;
	logic        advance;

	assign advance   = valid_s1 && (!res_valid_q || status.ready);
	assign cmd.ready = !valid_s1 || advance;

	dcp_parse_core #(
		.CaptureWindow(CaptureWindow)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (status.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign status.valid = res_valid_q;
	assign status.data  = res_q;

endmodule
